// File: design/rapc_pkg.sv
// ----------------------------------------------------------------------------
// rapc_pkg: shared types and constants for the RGBA alpha converter
// Pixel channel width, conversion direction codes and pipeline control.
// ----------------------------------------------------------------------------
`default_nettype none

package rapc_pkg;

  localparam int unsigned PIX_W = 8;

  // rounding bias of the premultiply quotient (c*a + 127) / 255
  localparam logic [2*PIX_W-1:0] PREMUL_BIAS = 16'd127;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    DIR_PREMUL   = 1'b0,
    DIR_UNPREMUL = 1'b1
  } dir_t;

  // control that travels alongside one pixel in the pipeline
  typedef struct packed {
    logic valid;
    dir_t dir;
  } rapc_ctl_t;

endpackage

`default_nettype wire

// File: design/rapc_lane.sv
// ----------------------------------------------------------------------------
// rapc_lane: one color channel of the alpha converter
// Stage 2 multiplies, stage 3 rounds, divides or shifts, and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module rapc_lane import rapc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire logic                      clk,
  input  wire rapc_ctl_t                 ctl_s1,
  input  wire pix_t                      color_s1,
  input  wire pix_t                      alpha_s1,
  input  wire logic [FRACTION_BITS+7:0]  scale_s1,
  input  wire logic                      valid_s2,
  output      pix_t                      color_out
);

  localparam int unsigned SCALE_W = FRACTION_BITS + PIX_W;
  localparam int unsigned PROD_W  = SCALE_W + PIX_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  logic [PROD_W-1:0]  prod_r,  prod_nxt;
  logic [2*PIX_W-1:0] pre_r,   pre_nxt;
  dir_t               dir_s2_r;
  pix_t               color_r, color_nxt;

  logic [PROD_W-1:0]  rnd_sum;
  logic [PROD_W-1:0]  quot_wide;
  logic [2*PIX_W:0]   div_sum;
  pix_t               unpre_val;
  pix_t               pre_val;

  // stage 2: both products, picked at stage 3 by direction
  always_comb begin
    prod_nxt = PROD_W'(color_s1) * PROD_W'(scale_s1);
    pre_nxt  = ((2*PIX_W)'(color_s1) * (2*PIX_W)'(alpha_s1)) + PREMUL_BIAS;
  end

  always_ff @(posedge clk) begin
    if (ctl_s1.valid) begin
      prod_r   <= prod_nxt;
      pre_r    <= pre_nxt;
      dir_s2_r <= ctl_s1.dir;
    end
  end

  // stage 3
  always_comb begin
    rnd_sum   = prod_r + HALF;
    quot_wide = rnd_sum >> FRACTION_BITS;
    unpre_val = (quot_wide > PROD_W'(255)) ? pix_t'(255) : quot_wide[PIX_W-1:0];
    // floor(x / 255) for x up to 65534
    div_sum   = (2*PIX_W+1)'(pre_r) + (2*PIX_W+1)'(pre_r >> PIX_W) + (2*PIX_W+1)'(1);
    pre_val   = div_sum[2*PIX_W-1:PIX_W];
    case (dir_s2_r)
      DIR_PREMUL:   color_nxt = pre_val;
      DIR_UNPREMUL: color_nxt = unpre_val;
      default:      color_nxt = pre_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (valid_s2) begin
      color_r <= color_nxt;
    end
  end

  assign color_out = color_r;

endmodule

`default_nettype wire

// File: design/rgba_alpha_premultiply_convert.sv
// ----------------------------------------------------------------------------
// rgba_alpha_premultiply_convert: RGBA8 premultiply / unpremultiply
// Converts one pixel per clock between straight and premultiplied alpha.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | transaction when
//  ---------+-----------------------------------------+---------------------------
//  input    | start, busy, in_red/green/blue/alpha    | start && !busy
//  result   | out_valid, out_red/green/blue/alpha     | out_valid (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_direction     | cfg_valid && cfg_ready
//
//  A new pixel may start in every cycle. Stage 1 reads the reciprocal ROM,
//  stage 2 holds the per-channel multiplier, stage 3 rounds, divides and
//  saturates; out_valid comes from the stage 3 valid register.
//  busy stays low and cfg_ready stays high. Reset clears the valid bits and
//  sets direction to premultiply. The receiver cannot stall, so nothing holds.
//
`default_nettype none

module rgba_alpha_premultiply_convert import rapc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input transactions
  input  wire logic start,
  output      logic busy,
  input  wire pix_t in_red,
  input  wire pix_t in_green,
  input  wire pix_t in_blue,
  input  wire pix_t in_alpha,
  // result transactions
  output      logic out_valid,
  output      pix_t out_red,
  output      pix_t out_green,
  output      pix_t out_blue,
  output      pix_t out_alpha,
  // configuration
  input  wire logic cfg_valid,
  output      logic cfg_ready,
  input  wire logic cfg_direction
);

  localparam int unsigned SCALE_W = FRACTION_BITS + PIX_W;

  // Reciprocal ROM: ceil((255 << FRACTION_BITS) / a). Entry 0 holds zero, so
  // alpha zero yields zero color; entry 255 holds exactly one, so opaque
  // pixels pass through the multiply unchanged.
  logic [SCALE_W-1:0] recip_rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam longint unsigned NUM = 64'd255 << FRACTION_BITS;
    localparam longint unsigned DEN = (g == 0) ? 64'd1 : 64'(g);
    localparam logic [SCALE_W-1:0] ENTRY =
      (g == 0) ? '0 : SCALE_W'((NUM + DEN - 64'd1) / DEN);
    assign recip_rom[g] = ENTRY;
  end

  // configuration register
  dir_t dir_r, dir_nxt;

  assign cfg_ready = 1'b1;
  assign dir_nxt   = (cfg_valid && cfg_ready) ? dir_t'(cfg_direction) : dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_PREMUL;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // input side never pushes back
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture the pixel and its reciprocal
  rapc_ctl_t          ctl_s1_r, ctl_s1_nxt;
  pix_t               red_s1_r, green_s1_r, blue_s1_r, alpha_s1_r;
  logic [SCALE_W-1:0] scale_s1_r;

  assign ctl_s1_nxt = '{valid: accept, dir: dir_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r <= '{valid: 1'b0, dir: DIR_PREMUL};
    end else begin
      ctl_s1_r <= ctl_s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_s1_r   <= in_red;
      green_s1_r <= in_green;
      blue_s1_r  <= in_blue;
      alpha_s1_r <= in_alpha;
      scale_s1_r <= recip_rom[in_alpha];
    end
  end

  // stages 2 and 3: valid bits and the alpha that rides along
  logic valid_s2_r, valid_s3_r;
  pix_t alpha_s2_r, alpha_s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s2_r <= 1'b0;
      valid_s3_r <= 1'b0;
    end else begin
      valid_s2_r <= ctl_s1_r.valid;
      valid_s3_r <= valid_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_s1_r.valid) begin
      alpha_s2_r <= alpha_s1_r;
    end
    if (valid_s2_r) begin
      alpha_s3_r <= alpha_s2_r;
    end
  end

  // one lane per color channel
  rapc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
    .clk       (clk),
    .ctl_s1    (ctl_s1_r),
    .color_s1  (red_s1_r),
    .alpha_s1  (alpha_s1_r),
    .scale_s1  (scale_s1_r),
    .valid_s2  (valid_s2_r),
    .color_out (out_red)
  );

  rapc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
    .clk       (clk),
    .ctl_s1    (ctl_s1_r),
    .color_s1  (green_s1_r),
    .alpha_s1  (alpha_s1_r),
    .scale_s1  (scale_s1_r),
    .valid_s2  (valid_s2_r),
    .color_out (out_green)
  );

  rapc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
    .clk       (clk),
    .ctl_s1    (ctl_s1_r),
    .color_s1  (blue_s1_r),
    .alpha_s1  (alpha_s1_r),
    .scale_s1  (scale_s1_r),
    .valid_s2  (valid_s2_r),
    .color_out (out_blue)
  );

  assign out_valid = valid_s3_r;
  assign out_alpha = alpha_s3_r;

endmodule

`default_nettype wire

// File: design/rapc_chk.sv
// ----------------------------------------------------------------------------
// rapc_chk: port-level checks for the RGBA alpha converter
// Watches latency, alpha pass-through and the two fixed color cases.
// ----------------------------------------------------------------------------
`default_nettype none

module rapc_chk import rapc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire pix_t in_red,
  input wire pix_t in_green,
  input wire pix_t in_blue,
  input wire pix_t in_alpha,
  input wire logic out_valid,
  input wire pix_t out_red,
  input wire pix_t out_green,
  input wire pix_t out_blue,
  input wire pix_t out_alpha
);

  // every accepted transaction comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted pixel produced no result");

  // no result without an earlier accepted transaction
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without accepted pixel");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == $past(in_alpha, 3)))
    else $error("alpha not passed through");

  // opaque pixels come out unchanged in either direction
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == 8'd255) |->
      (out_red == $past(in_red, 3) && out_green == $past(in_green, 3) &&
       out_blue == $past(in_blue, 3)))
    else $error("opaque pixel color changed");

  // fully transparent pixels come out black in either direction
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == 8'd0) |->
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("transparent pixel has color");

endmodule

bind rgba_alpha_premultiply_convert rapc_chk u_rapc_chk (.*);

`default_nettype wire
